@@ design/cna_pkg.sv @@
// Shared types, opcodes and the saturation helper of the complex arithmetic unit.
// Used by cna_div_pipe and complex_number_alu; depends on nothing else.
`timescale 1ns / 1ps

package cna_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 64;
  // Quotient bits produced by the divider, one per stage; the top bit catches overflow.
  localparam int unsigned QBITS  = 33;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_NEG   = 3'd4,
    CMD_RECIP = 3'd5,
    CMD_EQ    = 3'd6,
    CMD_MAG   = 3'd7
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic              eq;
    logic              neg_re;
    logic              neg_im;
    logic [DATA_W-1:0] fin_re;
    logic [DATA_W-1:0] fin_im;
    logic              fin_ovf;
  } side_t;

  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [QBITS-1:0]  xlo;
    logic [QBITS-1:0]  quo;
    logic              cap;
  } lane_t;

  typedef struct packed {
    side_t             side;
    logic              dz;
    logic [PROD_W-1:0] den;
    lane_t             re;
    lane_t             im;
  } dv_t;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] val;
  } sat_t;

  // Saturates a sign and magnitude pair to a 32-bit two's complement value.
  function automatic sat_t sat_mag(input logic neg, input logic [PROD_W:0] mag);
    sat_t               r;
    logic [PROD_W:0]    t;
    t = (~mag) + 65'd1;
    if (neg) begin
      if (mag > 65'h0_8000_0000) begin
        r.ovf = 1'b1;
        r.val = 32'h8000_0000;
      end else begin
        r.ovf = 1'b0;
        r.val = t[DATA_W-1:0];
      end
    end else begin
      if (mag > 65'h0_7FFF_FFFF) begin
        r.ovf = 1'b1;
        r.val = 32'h7FFF_FFFF;
      end else begin
        r.ovf = 1'b0;
        r.val = mag[DATA_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

@@ design/complex_number_alu.sv @@
// Top level of the complex arithmetic unit: operand, multiply, sum and prepare stages,
// the divider pipeline and the output register. Depends on cna_pkg and cna_div_pipe.
`timescale 1ns / 1ps

// Every opcode runs through the same 39-stage pipeline: five stages for operand capture,
// the six 32x32 multipliers, the sums of products, magnitudes and divider set-up, then
// 33 divider stages that each resolve one quotient bit, then the output register. The
// unit takes one transfer per clock when nothing stalls; a stage that holds no item
// still accepts while a later stage waits, so a waiting result does not stop new
// transfers until the bubbles are used up.
module complex_number_alu #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] res_re_o,
  output logic signed [31:0] res_im_o,
  output logic               is_equal_o,
  output logic               div_zero_o,
  output logic               overflow_o
);

  localparam int unsigned SH = cna_pkg::QBITS - FRAC_BITS;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  logic en1, en2, en3, en4, en5, eno;
  logic dv_rdy, dv_ov;
  cna_pkg::dv_t dv_out;

  // Stage 1: operands
  cna_pkg::cmd_e      cmd1_q;
  logic signed [31:0] ar1_q, ai1_q, br1_q, bi1_q;

  // Stage 2: products and finished add, subtract, negate and equal results
  logic signed [63:0] m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;
  logic signed [63:0] m0_d, m1_d, m2_d, m3_d, m4_d, m5_d;
  logic signed [31:0] da, db;
  logic signed [31:0] ar2_q, ai2_q;
  cna_pkg::side_t     side2_q, side2_d;
  logic signed [32:0] sum_re, sum_im;

  // Stage 3: signed sums and denominator
  logic signed [64:0] sr3_q, si3_q, sr3_d, si3_d;
  logic [63:0]        den3_q, den3_d;
  cna_pkg::side_t     side3_q;

  // Stage 4: magnitudes
  logic [63:0]        nr4_q, ni4_q, nr4_d, ni4_d;
  logic [64:0]        mr_w, mi_w;
  logic [63:0]        den4_q;
  logic               dz4_q;
  cna_pkg::side_t     side4_q, side4_d;

  // Stage 5: divider set-up
  cna_pkg::dv_t       s5_q, s5_d;

  // Output register
  logic [31:0]        res_re_q, res_im_q, res_re_d, res_im_d;
  logic               eq_q, dz_q, ovf_q, eq_d, dz_d, ovf_d;

  assign eno = ~vo_q | out_ready_i;
  assign en5 = ~v5_q | dv_rdy;
  assign en4 = ~v4_q | en5;
  assign en3 = ~v3_q | en4;
  assign en2 = ~v2_q | en3;
  assign en1 = ~v1_q | en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
      if (eno) begin
        vo_q <= dv_ov;
      end
    end
  end

  // ---------------- stage 1 -> 2 ----------------
  always_comb begin
    da   = (cmd1_q == cna_pkg::CMD_DIV) ? br1_q : ar1_q;
    db   = (cmd1_q == cna_pkg::CMD_DIV) ? bi1_q : ai1_q;
    m0_d = ar1_q * br1_q;
    m1_d = ai1_q * bi1_q;
    m2_d = ar1_q * bi1_q;
    m3_d = ai1_q * br1_q;
    m4_d = da * da;
    m5_d = db * db;

    unique case (cmd1_q)
      cna_pkg::CMD_SUB: begin
        sum_re = {ar1_q[31], ar1_q} - {br1_q[31], br1_q};
        sum_im = {ai1_q[31], ai1_q} - {bi1_q[31], bi1_q};
      end
      cna_pkg::CMD_NEG: begin
        sum_re = 33'sd0 - {ar1_q[31], ar1_q};
        sum_im = 33'sd0 - {ai1_q[31], ai1_q};
      end
      default: begin
        sum_re = {ar1_q[31], ar1_q} + {br1_q[31], br1_q};
        sum_im = {ai1_q[31], ai1_q} + {bi1_q[31], bi1_q};
      end
    endcase

    side2_d        = '0;
    side2_d.cmd    = cmd1_q;
    if (cmd1_q == cna_pkg::CMD_ADD || cmd1_q == cna_pkg::CMD_SUB ||
        cmd1_q == cna_pkg::CMD_NEG) begin
      // A 33-bit sum whose top two bits differ has left the 32-bit range.
      side2_d.fin_re  = (sum_re[32] != sum_re[31]) ?
                        (sum_re[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_re[31:0];
      side2_d.fin_im  = (sum_im[32] != sum_im[31]) ?
                        (sum_im[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_im[31:0];
      side2_d.fin_ovf = (sum_re[32] != sum_re[31]) | (sum_im[32] != sum_im[31]);
    end
    side2_d.eq = (cmd1_q == cna_pkg::CMD_EQ) && (ar1_q == br1_q) && (ai1_q == bi1_q);
  end

  // ---------------- stage 2 -> 3 ----------------
  always_comb begin
    den3_d = $unsigned(m4_q) + $unsigned(m5_q);
    unique case (side2_q.cmd)
      cna_pkg::CMD_MUL: begin
        sr3_d = {m0_q[63], m0_q} - {m1_q[63], m1_q};
        si3_d = {m2_q[63], m2_q} + {m3_q[63], m3_q};
      end
      cna_pkg::CMD_DIV: begin
        sr3_d = {m0_q[63], m0_q} + {m1_q[63], m1_q};
        si3_d = {m3_q[63], m3_q} - {m2_q[63], m2_q};
      end
      cna_pkg::CMD_RECIP: begin
        sr3_d = 65'(ar2_q);
        si3_d = 65'sd0 - 65'(ai2_q);
      end
      cna_pkg::CMD_MAG: begin
        sr3_d = {m4_q[63], m4_q} + {m5_q[63], m5_q};
        si3_d = '0;
      end
      default: begin
        sr3_d = '0;
        si3_d = '0;
      end
    endcase
  end

  // ---------------- stage 3 -> 4 ----------------
  always_comb begin
    mr_w    = sr3_q[64] ? (65'sd0 - sr3_q) : sr3_q;
    mi_w    = si3_q[64] ? (65'sd0 - si3_q) : si3_q;
    side4_d = side3_q;
    side4_d.neg_re = sr3_q[64];
    side4_d.neg_im = si3_q[64];
    // The reciprocal numerator carries one extra scaling by the fraction width.
    if (side3_q.cmd == cna_pkg::CMD_RECIP) begin
      nr4_d = mr_w[63:0] << FRAC_BITS;
      ni4_d = mi_w[63:0] << FRAC_BITS;
    end else begin
      nr4_d = mr_w[63:0];
      ni4_d = mi_w[63:0];
    end
  end

  // ---------------- stage 4 -> 5 ----------------
  always_comb begin
    logic [63:0]   hr, hi, xr, xi;
    cna_pkg::sat_t pr, pi;
    hr = nr4_q >> SH;
    hi = ni4_q >> SH;
    xr = nr4_q << FRAC_BITS;
    xi = ni4_q << FRAC_BITS;
    pr = cna_pkg::sat_mag(side4_q.neg_re, {1'b0, nr4_q >> FRAC_BITS});
    pi = cna_pkg::sat_mag(side4_q.neg_im, {1'b0, ni4_q >> FRAC_BITS});

    s5_d        = '0;
    s5_d.side   = side4_q;
    s5_d.dz     = dz4_q;
    s5_d.den    = den4_q;
    s5_d.re.rem = hr;
    s5_d.im.rem = hi;
    s5_d.re.xlo = xr[cna_pkg::QBITS-1:0];
    s5_d.im.xlo = xi[cna_pkg::QBITS-1:0];
    // A remainder that already reaches the divisor means the quotient needs 34 bits or more.
    s5_d.re.cap = (hr >= den4_q);
    s5_d.im.cap = (hi >= den4_q);
    if (side4_q.cmd == cna_pkg::CMD_MUL) begin
      s5_d.side.fin_re  = pr.val;
      s5_d.side.fin_im  = pi.val;
      s5_d.side.fin_ovf = pr.ovf | pi.ovf;
    end else if (side4_q.cmd == cna_pkg::CMD_MAG) begin
      s5_d.side.fin_re  = pr.val;
      s5_d.side.fin_im  = '0;
      s5_d.side.fin_ovf = pr.ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cmd1_q <= cna_pkg::cmd_e'(command_i);
      ar1_q  <= a_re_i;
      ai1_q  <= a_im_i;
      br1_q  <= b_re_i;
      bi1_q  <= b_im_i;
    end
    if (en2) begin
      m0_q    <= m0_d;
      m1_q    <= m1_d;
      m2_q    <= m2_d;
      m3_q    <= m3_d;
      m4_q    <= m4_d;
      m5_q    <= m5_d;
      ar2_q   <= ar1_q;
      ai2_q   <= ai1_q;
      side2_q <= side2_d;
    end
    if (en3) begin
      sr3_q   <= sr3_d;
      si3_q   <= si3_d;
      den3_q  <= den3_d;
      side3_q <= side2_q;
    end
    if (en4) begin
      nr4_q   <= nr4_d;
      ni4_q   <= ni4_d;
      den4_q  <= den3_q;
      dz4_q   <= (den3_q == 64'd0);
      side4_q <= side4_d;
    end
    if (en5) begin
      s5_q <= s5_d;
    end
    if (eno) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      eq_q     <= eq_d;
      dz_q     <= dz_d;
      ovf_q    <= ovf_d;
    end
  end

  cna_div_pipe u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v5_q),
    .in_ready_o  (dv_rdy),
    .in_data_i   (s5_q),
    .out_valid_o (dv_ov),
    .out_ready_i (eno),
    .out_data_o  (dv_out)
  );

  // ---------------- final selection ----------------
  always_comb begin
    cna_pkg::sat_t qr, qi;
    qr = cna_pkg::sat_mag(dv_out.side.neg_re,
                          dv_out.re.cap ? 65'h1_0000_0000 : {32'd0, dv_out.re.quo});
    qi = cna_pkg::sat_mag(dv_out.side.neg_im,
                          dv_out.im.cap ? 65'h1_0000_0000 : {32'd0, dv_out.im.quo});
    eq_d = dv_out.side.eq;
    if (dv_out.side.cmd == cna_pkg::CMD_DIV || dv_out.side.cmd == cna_pkg::CMD_RECIP) begin
      if (dv_out.dz) begin
        res_re_d = 32'h7FFF_FFFF;
        res_im_d = 32'h7FFF_FFFF;
        dz_d     = 1'b1;
        ovf_d    = 1'b1;
      end else begin
        res_re_d = qr.val;
        res_im_d = qi.val;
        dz_d     = 1'b0;
        ovf_d    = qr.ovf | qi.ovf;
      end
    end else begin
      res_re_d = dv_out.side.fin_re;
      res_im_d = dv_out.side.fin_im;
      dz_d     = 1'b0;
      ovf_d    = dv_out.side.fin_ovf;
    end
  end

  assign out_valid_o = vo_q;
  assign res_re_o    = res_re_q;
  assign res_im_o    = res_im_q;
  assign is_equal_o  = eq_q;
  assign div_zero_o  = dz_q;
  assign overflow_o  = ovf_q;

`ifndef SYNTHESIS
  a_eq_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_equal_o |-> !overflow_o && !div_zero_o)
    else $error("equality result carries an error flag");

  a_eq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_equal_o |-> res_re_o == 32'sd0 && res_im_o == 32'sd0)
    else $error("equality result has non-zero value");

  a_dz_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_zero_o |-> overflow_o && res_re_o == 32'sh7FFF_FFFF &&
                                   res_im_o == 32'sh7FFF_FFFF)
    else $error("zero divisor result not saturated");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted transfer did not reach the operand stage");
`endif

endmodule

@@ design/cna_div_pipe.sv @@
// Pipelined restoring divider: one quotient bit per stage for both result parts.
// Depends on cna_pkg for the stage record and the quotient width.
`timescale 1ns / 1ps

module cna_div_pipe (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  cna_pkg::dv_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output cna_pkg::dv_t out_data_o
);

  localparam int unsigned N = cna_pkg::QBITS;

  cna_pkg::dv_t    stg_q [N];
  cna_pkg::dv_t    src   [N];
  logic [N-1:0]    vld_q;
  logic [N-1:0]    src_v;
  logic [N-1:0]    en;

  // Shift the next dividend bit into the remainder and subtract the divisor if it fits.
  function automatic cna_pkg::lane_t step(input cna_pkg::lane_t l, input logic [63:0] den);
    cna_pkg::lane_t r;
    logic [64:0]    r2;
    logic [64:0]    diff;
    logic           ge;
    r2   = {l.rem, l.xlo[N-1]};
    diff = r2 - {1'b0, den};
    ge   = (r2 >= {1'b0, den});
    r     = l;
    r.rem = ge ? diff[63:0] : r2[63:0];
    r.xlo = {l.xlo[N-2:0], 1'b0};
    r.quo = {l.quo[N-2:0], ge};
    return r;
  endfunction

  for (genvar k = 0; k < N; k++) begin : g_stage
    cna_pkg::dv_t nxt;

    if (k == 0) begin : g_first
      assign src[k]   = in_data_i;
      assign src_v[k] = in_valid_i;
    end else begin : g_rest
      assign src[k]   = stg_q[k-1];
      assign src_v[k] = vld_q[k-1];
    end

    if (k == N - 1) begin : g_last
      assign en[k] = ~vld_q[k] | out_ready_i;
    end else begin : g_mid
      assign en[k] = ~vld_q[k] | en[k+1];
    end

    always_comb begin
      nxt    = src[k];
      nxt.re = step(src[k].re, src[k].den);
      nxt.im = step(src[k].im, src[k].den);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en[k]) begin
        vld_q[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        stg_q[k] <= nxt;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[N-1];
  assign out_data_o  = stg_q[N-1];

endmodule
